/* src/plcat_pkg.sv */
// Shared types and constants for the PLC address text parser.
`default_nettype none

package plcat_pkg;

    // Fixed field widths of the request and result items.
    localparam int CH_W     = 8;
    localparam int LEN_W    = 16;
    localparam int AREA_W   = 8;
    localparam int BLOCK_W  = 16;
    localparam int START_W  = 24;

    // Default limits for the numeric fields.
    localparam int ADDR_BITS_DEF  = 24;
    localparam int BLOCK_BITS_DEF = 16;

    // Memory area codes.
    localparam logic [AREA_W-1:0] AREA_I  = 8'h81;
    localparam logic [AREA_W-1:0] AREA_Q  = 8'h82;
    localparam logic [AREA_W-1:0] AREA_M  = 8'h83;
    localparam logic [AREA_W-1:0] AREA_DB = 8'h84;
    localparam logic [AREA_W-1:0] AREA_AI = 8'h06;
    localparam logic [AREA_W-1:0] AREA_AQ = 8'h07;
    localparam logic [AREA_W-1:0] AREA_T  = 8'h1F;
    localparam logic [AREA_W-1:0] AREA_C  = 8'h1E;

    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic             last;
        logic [LEN_W-1:0] read_length;
    } in_item_t;

    typedef struct packed {
        logic               valid_res;
        logic [AREA_W-1:0]  area_code;
        logic [BLOCK_W-1:0] block_number;
        logic [START_W-1:0] start_bit_address;
        logic [LEN_W-1:0]   length_out;
    } out_item_t;

endpackage

`default_nettype wire

/* src/plc_address_text_parser.sv */
// Top level of the PLC address text parser: request and result registers.
//
// Usage: the address text (for example "DB10.DBX4.3", "MW20", "I0.5", "T7")
// enters on the s_ channel one character per request, letters in either case,
// with s_data.last set on the final character; s_data.read_length is taken
// from that final request. Each final character produces exactly one result
// on the m_ channel with the valid flag, area code, block number, start bit
// address and the passed-through length; other characters produce none.
// A final character is first loaded into the request register, and its result
// is then loaded into the result register. Throughput: one character per
// cycle, except while a final character waits for the result register.
// Reset (aresetn low at a clock edge) empties both registers and returns the
// parse state to the start of a text. When the receiver stalls, the result
// register holds its item; the request register keeps taking characters that
// produce no result, and a final character waits there, with s_ready low,
// until the result register is free.
`default_nettype none

module plc_address_text_parser
    import plcat_pkg::*;
#(
    parameter int ADDR_BITS  = ADDR_BITS_DEF,
    parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    logic       in_vld_reg;
    in_item_t   in_item_reg;
    logic       out_vld_reg;
    out_item_t  out_item_reg;
    out_item_t  result;
    logic       fire;

    // A non-final character needs no result slot; a final one does.
    assign fire    = in_vld_reg && (!in_item_reg.last || !out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || fire;
    assign m_valid = out_vld_reg;
    assign m_data  = out_item_reg;

    plcat_parser #(
        .ADDR_BITS  (ADDR_BITS),
        .BLOCK_BITS (BLOCK_BITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (fire && in_item_reg.last) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && in_item_reg.last) begin
            out_item_reg <= result;
        end
    end

    // An invalid result carries only the length.
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.valid_res |->
            m_data.area_code == '0 && m_data.block_number == '0 &&
            m_data.start_bit_address == '0)
        else $error("invalid result carries nonzero address fields");

    a_valid_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.valid_res |-> m_data.length_out != '0)
        else $error("valid result with zero length");

    a_valid_area: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.valid_res |->
            m_data.area_code == AREA_I || m_data.area_code == AREA_Q ||
            m_data.area_code == AREA_M || m_data.area_code == AREA_DB ||
            m_data.area_code == AREA_AI || m_data.area_code == AREA_AQ ||
            m_data.area_code == AREA_T || m_data.area_code == AREA_C)
        else $error("valid result with unknown area code");

    a_last_makes_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_item_reg.last |=> m_valid)
        else $error("final character did not produce a result");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_vld_reg && in_item_reg.last && out_vld_reg && !m_ready)
        else $error("request side stalled without a pending final character");

endmodule

`default_nettype wire

/* src/plcat_parser.sv */
// Character-by-character parse state and result formation for the address parser.
`default_nettype none

module plcat_parser
    import plcat_pkg::*;
#(
    parameter int ADDR_BITS  = ADDR_BITS_DEF,
    parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      fire,
    input  wire in_item_t  item,
    output out_item_t      result
);

    localparam int BW = BLOCK_BITS + 1;
    localparam int AW = ADDR_BITS + 1;

    localparam logic [CH_W-1:0] CH_A   = "A";
    localparam logic [CH_W-1:0] CH_B   = "B";
    localparam logic [CH_W-1:0] CH_C   = "C";
    localparam logic [CH_W-1:0] CH_D   = "D";
    localparam logic [CH_W-1:0] CH_I   = "I";
    localparam logic [CH_W-1:0] CH_M   = "M";
    localparam logic [CH_W-1:0] CH_Q   = "Q";
    localparam logic [CH_W-1:0] CH_T   = "T";
    localparam logic [CH_W-1:0] CH_V   = "V";
    localparam logic [CH_W-1:0] CH_W_  = "W";
    localparam logic [CH_W-1:0] CH_X   = "X";
    localparam logic [CH_W-1:0] CH_DOT = ".";
    localparam logic [CH_W-1:0] CH_0   = "0";
    localparam logic [CH_W-1:0] CH_9   = "9";
    localparam logic [CH_W-1:0] CH_LA  = "a";
    localparam logic [CH_W-1:0] CH_LZ  = "z";
    localparam logic [CH_W-1:0] CASE_OFS = 8'h20;

    typedef enum logic [15:0] {
        PH_START  = 16'h0001,
        PH_A      = 16'h0002,
        PH_D      = 16'h0004,
        PH_DB0    = 16'h0008,
        PH_DBNUM  = 16'h0010,
        PH_DBDOT  = 16'h0020,
        PH_SUF_D  = 16'h0040,
        PH_SUF_DB = 16'h0080,
        PH_SIZE   = 16'h0100,
        PH_CT0    = 16'h0200,
        PH_CTNUM  = 16'h0400,
        PH_BYTE0  = 16'h0800,
        PH_BYTE   = 16'h1000,
        PH_BIT0   = 16'h2000,
        PH_BIT    = 16'h4000,
        PH_BAD    = 16'h8000
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [AREA_W-1:0]   area_reg, area_next;
    logic [BW-1:0]       blk_reg, blk_next;
    logic [AW-1:0]       byt_reg, byt_next;
    logic [3:0]          bit_reg, bit_next;
    logic                ovf_reg, ovf_next;

    logic [CH_W-1:0]     c;
    logic                is_dig;
    logic                is_size;
    logic [3:0]          dval;
    logic                blk_take, byt_take, bit_take;

    logic [BW+3:0]       bext, bprod;
    logic [AW+3:0]       yext, yprod;
    logic [6:0]          bitprod;
    logic                blk_over, byt_over;

    logic                ok;
    logic                byte_big;
    logic [ADDR_BITS-1:0] start;

    // Upper-case the character and classify it.
    always_comb begin
        if (item.ch >= CH_LA && item.ch <= CH_LZ) begin
            c = item.ch - CASE_OFS;
        end else begin
            c = item.ch;
        end
        is_dig  = (c >= CH_0) && (c <= CH_9);
        dval    = is_dig ? 4'(c - CH_0) : 4'd0;
        is_size = (c == CH_X) || (c == CH_B) || (c == CH_W_) || (c == CH_D);
    end

    // Multiply-by-ten accumulators; a value past its limit saturates at limit + 1.
    always_comb begin
        bext     = {4'b0000, blk_reg};
        bprod    = (bext << 3) + (bext << 1) + (BW+4)'(dval);
        blk_over = |bprod[BW+3:BLOCK_BITS];
        yext     = {4'b0000, byt_reg};
        yprod    = (yext << 3) + (yext << 1) + (AW+4)'(dval);
        byt_over = |yprod[AW+3:ADDR_BITS];
        bitprod  = 7'({3'b000, bit_reg} * 7'd10) + 7'(dval);
    end

    always_comb begin
        phase_next = PH_BAD;
        area_next  = area_reg;
        blk_take   = 1'b0;
        byt_take   = 1'b0;
        bit_take   = 1'b0;

        unique case (phase_reg)
            PH_START: begin
                case (c)
                    CH_A: phase_next = PH_A;
                    CH_D: begin area_next = AREA_DB; phase_next = PH_D; end
                    CH_I: begin area_next = AREA_I; phase_next = PH_SIZE; end
                    CH_Q: begin area_next = AREA_Q; phase_next = PH_SIZE; end
                    CH_M: begin area_next = AREA_M; phase_next = PH_SIZE; end
                    CH_V: begin area_next = AREA_DB; phase_next = PH_SIZE; end
                    CH_T: begin area_next = AREA_T; phase_next = PH_CT0; end
                    CH_C: begin area_next = AREA_C; phase_next = PH_CT0; end
                    default: phase_next = PH_BAD;
                endcase
            end
            PH_A: begin
                if (c == CH_I) begin
                    area_next  = AREA_AI;
                    phase_next = PH_SIZE;
                end else if (c == CH_Q) begin
                    area_next  = AREA_AQ;
                    phase_next = PH_SIZE;
                end
            end
            PH_D: begin
                if (c == CH_B) begin
                    phase_next = PH_DB0;
                end else if (is_dig) begin
                    blk_take   = 1'b1;
                    phase_next = PH_DBNUM;
                end
            end
            PH_DB0: begin
                if (is_dig) begin
                    blk_take   = 1'b1;
                    phase_next = PH_DBNUM;
                end
            end
            PH_DBNUM: begin
                if (is_dig) begin
                    blk_take   = 1'b1;
                    phase_next = PH_DBNUM;
                end else if (c == CH_DOT) begin
                    phase_next = PH_DBDOT;
                end
            end
            PH_DBDOT: begin
                if (c == CH_D) begin
                    phase_next = PH_SUF_D;
                end else if (is_dig) begin
                    byt_take   = 1'b1;
                    phase_next = PH_BYTE;
                end
            end
            PH_SUF_D: begin
                if (c == CH_B) phase_next = PH_SUF_DB;
            end
            PH_SUF_DB: begin
                if (is_size) phase_next = PH_BYTE0;
            end
            PH_SIZE: begin
                if (is_size) begin
                    phase_next = PH_BYTE0;
                end else if (is_dig) begin
                    byt_take   = 1'b1;
                    phase_next = PH_BYTE;
                end
            end
            PH_CT0, PH_CTNUM: begin
                if (is_dig) begin
                    byt_take   = 1'b1;
                    phase_next = PH_CTNUM;
                end
            end
            PH_BYTE0: begin
                if (is_dig) begin
                    byt_take   = 1'b1;
                    phase_next = PH_BYTE;
                end
            end
            PH_BYTE: begin
                if (is_dig) begin
                    byt_take   = 1'b1;
                    phase_next = PH_BYTE;
                end else if (c == CH_DOT) begin
                    phase_next = PH_BIT0;
                end
            end
            PH_BIT0, PH_BIT: begin
                if (is_dig) begin
                    bit_take   = 1'b1;
                    phase_next = PH_BIT;
                end
            end
            default: phase_next = PH_BAD;
        endcase
    end

    always_comb begin
        blk_next = blk_reg;
        byt_next = byt_reg;
        bit_next = bit_reg;
        ovf_next = ovf_reg;
        if (blk_take) begin
            blk_next = blk_over ? {1'b1, {BLOCK_BITS{1'b0}}} : bprod[BW-1:0];
            ovf_next = ovf_reg | blk_over;
        end
        if (byt_take) begin
            byt_next = byt_over ? {1'b1, {ADDR_BITS{1'b0}}} : yprod[AW-1:0];
            ovf_next = ovf_reg | byt_over;
        end
        if (bit_take) begin
            bit_next = (bitprod > 7'd8) ? 4'd8 : bitprod[3:0];
        end
    end

    // A byte index above the address limit divided by eight cannot be scaled.
    assign byte_big = |byt_next[ADDR_BITS:ADDR_BITS-3];

    always_comb begin
        ok    = 1'b0;
        start = '0;
        case (phase_next)
            PH_DBNUM: ok = 1'b1;
            PH_CTNUM: begin
                ok    = 1'b1;
                start = byt_next[ADDR_BITS-1:0];
            end
            PH_BYTE: begin
                ok    = !byte_big;
                start = {byt_next[ADDR_BITS-4:0], 3'b000};
            end
            PH_BIT: begin
                ok    = !byte_big && (bit_next <= 4'd7);
                start = {byt_next[ADDR_BITS-4:0], bit_next[2:0]};
            end
            default: ok = 1'b0;
        endcase
        ok = ok && !ovf_next && (item.read_length != '0);

        result.valid_res         = ok;
        result.area_code         = ok ? area_next : '0;
        result.block_number      = ok ? BLOCK_W'(blk_next[BLOCK_BITS-1:0]) : '0;
        result.start_bit_address = ok ? START_W'(start) : '0;
        result.length_out        = item.read_length;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            area_reg  <= '0;
            blk_reg   <= '0;
            byt_reg   <= '0;
            bit_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else if (fire) begin
            if (item.last) begin
                phase_reg <= PH_START;
                area_reg  <= '0;
                blk_reg   <= '0;
                byt_reg   <= '0;
                bit_reg   <= '0;
                ovf_reg   <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                area_reg  <= area_next;
                blk_reg   <= blk_next;
                byt_reg   <= byt_next;
                bit_reg   <= bit_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the PLC address text parser.
`timescale 1ns / 100ps

module tb_top
    import plcat_pkg::*;
;

    typedef enum logic [3:0] {
        P_START, P_A, P_D, P_DB0, P_DBNUM, P_DBDOT, P_SUF_D, P_SUF_DB,
        P_SIZE, P_CT0, P_CTNUM, P_BYTE0, P_BYTE, P_BIT0, P_BIT, P_BAD
    } parse_phase_e;

    typedef struct {
        string       text;
        int          extra;
        logic [15:0] len;
        bit          typed;
        out_item_t   res;
    } vector_t;

    localparam longint unsigned ADDR_LIM  = (64'd1 << ADDR_BITS_DEF) - 1;
    localparam longint unsigned BLOCK_LIM = (64'd1 << BLOCK_BITS_DEF) - 1;
    localparam int RANDOM_CHARS = 1110;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // Parser shadow state.
    parse_phase_e    ps = P_START;
    logic [7:0]      ps_area = '0;
    longint unsigned blk_acc = 0;
    longint unsigned idx_acc = 0;
    int unsigned     bit_num = 0;
    bit              num_ovf = 1'b0;

    out_item_t   pending_results[$];
    vector_t     vectors[$];
    logic [7:0]  text_q[$];

    bit steady = 1'b0;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    int fail_cnt = 0;
    int results_seen = 0;
    int stall_cycles = 0;
    int chars_sent = 0;
    int texts_sent = 0;

    plc_address_text_parser dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("FAIL plc_address_text_parser");
        $finish;
    end

    function automatic longint unsigned mac10(longint unsigned acc, int unsigned d,
                                              longint unsigned lim);
        longint unsigned v;
        v = acc * 10 + d;
        if (v > lim) begin
            num_ovf = 1'b1;
            v = lim + 1;
        end
        return v;
    endfunction

    function automatic bit is_size(logic [7:0] c);
        return c == "X" || c == "B" || c == "W" || c == "D";
    endfunction

    // Advances the shadow parser by one character; returns 1 when a result is due.
    function automatic bit parse_step(in_item_t it, output out_item_t res);
        logic [7:0]      c;
        bit              dig;
        int unsigned     d;
        int unsigned     b;
        parse_phase_e    nxt;
        bit              ok;
        longint unsigned start;
        c = it.ch;
        res = '0;
        if (c >= "a" && c <= "z")
            c = c - 8'd32;
        dig = c >= "0" && c <= "9";
        d = dig ? c - "0" : 0;
        nxt = P_BAD;
        case (ps)
            P_START: begin
                case (c)
                    "A": nxt = P_A;
                    "D": begin ps_area = AREA_DB; nxt = P_D; end
                    "I": begin ps_area = AREA_I; nxt = P_SIZE; end
                    "Q": begin ps_area = AREA_Q; nxt = P_SIZE; end
                    "M": begin ps_area = AREA_M; nxt = P_SIZE; end
                    "V": begin ps_area = AREA_DB; nxt = P_SIZE; end
                    "T": begin ps_area = AREA_T; nxt = P_CT0; end
                    "C": begin ps_area = AREA_C; nxt = P_CT0; end
                    default: nxt = P_BAD;
                endcase
            end
            P_A: begin
                if (c == "I") begin ps_area = AREA_AI; nxt = P_SIZE; end
                else if (c == "Q") begin ps_area = AREA_AQ; nxt = P_SIZE; end
            end
            P_D: begin
                if (c == "B") nxt = P_DB0;
                else if (dig) begin blk_acc = mac10(0, d, BLOCK_LIM); nxt = P_DBNUM; end
            end
            P_DB0, P_DBNUM: begin
                if (dig) begin blk_acc = mac10(blk_acc, d, BLOCK_LIM); nxt = P_DBNUM; end
                else if (c == "." && ps == P_DBNUM) nxt = P_DBDOT;
            end
            P_DBDOT: begin
                if (c == "D") nxt = P_SUF_D;
                else if (dig) begin idx_acc = mac10(0, d, ADDR_LIM); nxt = P_BYTE; end
            end
            P_SUF_D: if (c == "B") nxt = P_SUF_DB;
            P_SUF_DB: if (is_size(c)) nxt = P_BYTE0;
            P_SIZE: begin
                if (is_size(c)) nxt = P_BYTE0;
                else if (dig) begin idx_acc = mac10(0, d, ADDR_LIM); nxt = P_BYTE; end
            end
            P_CT0, P_CTNUM: begin
                if (dig) begin idx_acc = mac10(idx_acc, d, ADDR_LIM); nxt = P_CTNUM; end
            end
            P_BYTE0, P_BYTE: begin
                if (dig) begin idx_acc = mac10(idx_acc, d, ADDR_LIM); nxt = P_BYTE; end
                else if (c == "." && ps == P_BYTE) nxt = P_BIT0;
            end
            P_BIT0, P_BIT: begin
                if (dig) begin
                    // The bit number saturates at eight so that long numbers stay invalid.
                    b = bit_num * 10 + d;
                    bit_num = (b > 8) ? 8 : b;
                    nxt = P_BIT;
                end
            end
            default: nxt = P_BAD;
        endcase
        ps = nxt;
        if (!it.last)
            return 1'b0;

        ok = 1'b0;
        start = 0;
        case (ps)
            P_DBNUM: ok = 1'b1;
            P_CTNUM: begin ok = 1'b1; start = idx_acc; end
            P_BYTE:  begin ok = 1'b1; start = idx_acc * 8; end
            P_BIT:   begin ok = bit_num <= 7; start = idx_acc * 8 + bit_num; end
            default: ok = 1'b0;
        endcase
        if (num_ovf || blk_acc > BLOCK_LIM || start > ADDR_LIM || it.read_length == 0)
            ok = 1'b0;
        res.valid_res         = ok;
        res.area_code         = ok ? ps_area : '0;
        res.block_number      = ok ? blk_acc[15:0] : '0;
        res.start_bit_address = ok ? start[23:0] : '0;
        res.length_out        = it.read_length;

        ps = P_START;
        ps_area = '0;
        blk_acc = 0;
        idx_acc = 0;
        bit_num = 0;
        num_ovf = 1'b0;
        return 1'b1;
    endfunction

    function automatic out_item_t mk_res(bit v, logic [7:0] area, logic [15:0] blk,
                                         logic [23:0] start, logic [15:0] len);
        out_item_t r;
        r.valid_res = v;
        r.area_code = area;
        r.block_number = blk;
        r.start_bit_address = start;
        r.length_out = len;
        return r;
    endfunction

    function automatic void add_row(string text, int extra, logic [15:0] len, bit typed,
                                    out_item_t res);
        vector_t v;
        v.text = text;
        v.extra = extra;
        v.len = len;
        v.typed = typed;
        v.res = res;
        vectors.push_back(v);
    endfunction

    // Letters go out in either case at random.
    function automatic void put_char(logic [7:0] c);
        if (c >= "A" && c <= "Z" && $urandom_range(1) == 1)
            c = c + 8'd32;
        text_q.push_back(c);
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i]);
    endfunction

    function automatic void put_num(longint unsigned v);
        if ($urandom_range(7) == 0)
            repeat ($urandom_range(1, 3)) text_q.push_back("0");
        put_str($sformatf("%0d", v));
    endfunction

    function automatic void put_bit();
        case ($urandom_range(7))
            0: text_q.push_back(8'("0" + $urandom_range(8, 9)));
            1: begin
                text_q.push_back("0");
                text_q.push_back(8'("0" + $urandom_range(9)));
            end
            2: put_num($urandom_range(10, 99));
            default: text_q.push_back(8'("0" + $urandom_range(7)));
        endcase
    endfunction

    function automatic longint unsigned pick_value(int unsigned lim);
        case ($urandom_range(9))
            6, 7: return $urandom_range(lim);
            8: return $urandom_range(lim + 2, lim - 1);
            9: return $urandom_range(99_999_999);
            default: return $urandom_range(99);
        endcase
    endfunction

    function automatic logic [7:0] size_char();
        string sizes = "XBWD";
        return sizes[$urandom_range(3)];
    endfunction

    // Builds one random text: mostly well formed, some damaged, some noise.
    function automatic void gen_text();
        string prefixes[6] = '{"I", "Q", "M", "V", "AI", "AQ"};
        string noise = "ABDIQMTCVXW.0123456789dbx";
        int unsigned kind;
        int unsigned n;
        text_q.delete();
        kind = $urandom_range(99);
        if (kind >= 90) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                if ($urandom_range(1) == 1)
                    text_q.push_back(8'($urandom_range(255)));
                else
                    text_q.push_back(noise[$urandom_range(noise.len() - 1)]);
            end
            return;
        end
        case ($urandom_range(2))
            0: begin
                put_str(prefixes[$urandom_range(5)]);
                if ($urandom_range(1) == 1)
                    put_char(size_char());
                put_num(pick_value(2_097_151));
                if ($urandom_range(1) == 1) begin
                    text_q.push_back(".");
                    put_bit();
                end
            end
            1: begin
                if ($urandom_range(1) == 1)
                    put_str("DB");
                else
                    put_str("D");
                put_num(pick_value(65_535));
                if ($urandom_range(3) != 0) begin
                    text_q.push_back(".");
                    if ($urandom_range(1) == 1) begin
                        put_str("DB");
                        put_char(size_char());
                    end
                    put_num(pick_value(2_097_151));
                    if ($urandom_range(1) == 1) begin
                        text_q.push_back(".");
                        put_bit();
                    end
                end
            end
            default: begin
                put_char(($urandom_range(1) == 1) ? "T" : "C");
                if ($urandom_range(9) == 8)
                    put_num($urandom_range(16_777_217, 16_777_214));
                else
                    put_num(pick_value(999));
            end
        endcase
        if (kind >= 80) begin
            n = $urandom_range(text_q.size() - 1);
            if ($urandom_range(1) == 1 && text_q.size() > 1)
                repeat ($urandom_range(1, text_q.size() - 1)) void'(text_q.pop_back());
            else
                text_q[n] = 8'($urandom_range(255));
        end
    endfunction

    // Offers the characters of text_q one request at a time.
    task automatic send_text(logic [15:0] len, bit typed, out_item_t typed_res);
        in_item_t  it;
        out_item_t r;
        for (int i = 0; i < text_q.size(); i++) begin
            it.ch = text_q[i];
            it.last = (i == text_q.size() - 1);
            it.read_length = it.last ? len : 16'($urandom);
            while (!steady && $urandom_range(99) < 25) begin
                s_valid = 1'b0;
                @(negedge aclk);
            end
            s_valid = 1'b1;
            s_data = it;
            do @(posedge aclk); while (!s_ready);
            chars_sent++;
            if (parse_step(it, r))
                pending_results.push_back(typed ? typed_res : r);
            @(negedge aclk);
        end
        texts_sent++;
    endtask

    function automatic logic [15:0] pick_len();
        case ($urandom_range(11))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(1, 65_535));
        endcase
    endfunction

    task automatic report_mismatch(string what, out_item_t want, out_item_t got);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display({"%s: want v=%0d area=%h blk=%0d start=%0d len=%0d,",
                      " got v=%0d area=%h blk=%0d start=%0d len=%0d"},
                     what, want.valid_res, want.area_code, want.block_number,
                     want.start_bit_address, want.length_out, got.valid_res,
                     got.area_code, got.block_number, got.start_bit_address,
                     got.length_out);
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && s_valid && !s_ready)
            stall_cycles++;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending", '0, m_data);
            end else begin
                want = pending_results.pop_front();
                if (want.valid_res !== m_data.valid_res ||
                    want.area_code !== m_data.area_code ||
                    want.block_number !== m_data.block_number ||
                    want.start_bit_address !== m_data.start_bit_address ||
                    want.length_out !== m_data.length_out)
                    report_mismatch("result mismatch", want, m_data);
            end
        end
    end

    // Result side: random back-pressure plus one long hold-off.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_go && !hold_done) begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else begin
                m_ready = steady || ($urandom_range(99) >= 25);
            end
        end
    end

    initial begin : main
        out_item_t none;
        int        random_chars;
        none = '0;

        add_row("MW20", -1, 16'd1, 1'b1, mk_res(1, AREA_M, 0, 160, 1));
        add_row("db10.dbx4.3", -1, 16'hFFFF, 1'b1, mk_res(1, AREA_DB, 10, 35, 16'hFFFF));
        add_row("I0.5", -1, 16'd3, 1'b1, mk_res(1, AREA_I, 0, 5, 3));
        add_row("T7", -1, 16'd2, 1'b1, mk_res(1, AREA_T, 0, 7, 2));
        add_row("C16777215", -1, 16'd9, 1'b1, mk_res(1, AREA_C, 0, 24'hFFFFFF, 9));
        add_row("c16777216", -1, 16'd9, 1'b1, mk_res(0, 0, 0, 0, 9));
        add_row("DB65535.DBD2097151.7", -1, 16'd4, 1'b1,
                mk_res(1, AREA_DB, 16'hFFFF, 24'hFFFFFF, 4));
        add_row("DB65536", -1, 16'd4, 1'b1, mk_res(0, 0, 0, 0, 4));
        add_row("I2097152", -1, 16'd5, 1'b1, mk_res(0, 0, 0, 0, 5));
        add_row("M0", -1, 16'd0, 1'b1, mk_res(0, 0, 0, 0, 0));
        add_row("I0.8", -1, 16'd1, 1'b1, mk_res(0, 0, 0, 0, 1));
        add_row("d12.dbb3", -1, 16'd7, 1'b0, none);
        add_row("AIW4", -1, 16'd8, 1'b0, none);
        add_row("aqb0", -1, 16'd8, 1'b0, none);
        add_row("VD100", -1, 16'd2, 1'b0, none);
        add_row("QX1.07", -1, 16'd2, 1'b0, none);
        add_row("DB5", -1, 16'd1, 1'b0, none);
        add_row("D3.6.1", -1, 16'd1, 1'b0, none);
        add_row("DB1.DBX", -1, 16'd6, 1'b1, mk_res(0, 0, 0, 0, 6));
        add_row("M1.2.3", -1, 16'd6, 1'b1, mk_res(0, 0, 0, 0, 6));
        add_row("T1.0", -1, 16'd6, 1'b1, mk_res(0, 0, 0, 0, 6));
        add_row("Q", -1, 16'd6, 1'b1, mk_res(0, 0, 0, 0, 6));
        add_row("M", 0, 16'd6, 1'b1, mk_res(0, 0, 0, 0, 6));
        add_row("M", 255, 16'd6, 1'b1, mk_res(0, 0, 0, 0, 6));
        add_row("X5", -1, 16'd6, 1'b1, mk_res(0, 0, 0, 0, 6));

        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (vectors[i]) begin
            text_q.delete();
            for (int k = 0; k < vectors[i].text.len(); k++)
                text_q.push_back(vectors[i].text[k]);
            if (vectors[i].extra >= 0)
                text_q.push_back(8'(vectors[i].extra));
            send_text(vectors[i].len, vectors[i].typed, vectors[i].res);
        end

        random_chars = 0;
        while (random_chars < RANDOM_CHARS) begin
            // A quiet stretch in the middle with no idling on either side.
            steady = random_chars >= 600 && random_chars < 900;
            if (random_chars >= 200)
                hold_go = 1'b1;
            gen_text();
            random_chars += text_q.size();
            send_text(pick_len(), 1'b0, none);
        end
        steady = 1'b0;
        s_valid = 1'b0;

        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);

        if (pending_results.size() != 0)
            fail_cnt += pending_results.size();
        $display("Sent %0d texts (%0d directed) as %0d characters; checked %0d results.",
                 texts_sent, vectors.size(), chars_sent, results_seen);
        $display("Input held off for %0d cycles; %0d failures.", stall_cycles, fail_cnt);
        if (fail_cnt == 0)
            $display("PASS plc_address_text_parser");
        else
            $display("FAIL plc_address_text_parser");
        $finish;
    end

endmodule
